FILE: hdl/ammav_pkg.sv
// Shared types, constants and sequencer states for the acceleration magnitude averager.
package ammav_pkg;

    localparam int WINDOW    = 5;
    localparam int AXIS_W    = 16;
    localparam int MAG_W     = 16;
    localparam int SUMSQ_W   = 32;
    localparam int MAG_MAX   = 56755;
    localparam int TOTAL_W   = $clog2(MAG_MAX * WINDOW + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RECIP_W   = TOTAL_W + 1;
    localparam int RECIP     = (1 << TOTAL_W) / WINDOW;
    localparam int MUL_W     = (RECIP_W > AXIS_W) ? RECIP_W : AXIS_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ROOT_STEPS = SUMSQ_W / 2;
    localparam int STEP_W    = $clog2(ROOT_STEPS);
    localparam int AXES      = 3;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } in_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic [MAG_W-1:0] window_average;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_RING,
        ST_DIV_MUL,
        ST_DIV_FIX
    } state_t;

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W-1:0] r;
        r = v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : AXIS_W'(v);
        return r;
    endfunction

endpackage

FILE: hdl/ammav_isqrt.sv
// Iterative floor square root, one bit pair per cycle.
module ammav_isqrt
    import ammav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUMSQ_W-1:0] radicand,
    output logic               done,
    output logic [MAG_W-1:0]   root
);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUMSQ_W-1:0] rem_reg;
    logic [SUMSQ_W-1:0] rem_next;
    logic [SUMSQ_W-1:0] root_reg;
    logic [SUMSQ_W-1:0] root_next;
    logic [SUMSQ_W-1:0] bit_val;
    logic [SUMSQ_W-1:0] trial;

    always_comb
    begin
        // bit walks down from 2^30 by two places per step
        bit_val = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * int'(step_reg));
        trial   = root_reg + bit_val;
        if (rem_reg >= trial)
        begin
            rem_next  = rem_reg - trial;
            root_next = (root_reg >> 1) + bit_val;
        end
        else
        begin
            rem_next  = rem_reg;
            root_next = root_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg  <= radicand;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg[MAG_W-1:0];

endmodule

FILE: hdl/accel_magnitude_moving_average_unit.sv
// Top level: vector magnitude of a three-axis sample and its boxcar average.
//
// Each accepted beat carries one signed x/y/z sample. The unit returns one beat with
// floor(sqrt(x^2+y^2+z^2)) and the floor average of the last WINDOW magnitudes, the
// new one included; the window starts out as zeros after reset. A sample passes through
// these steps from one acceptance to the next: the idle state that takes the beat, the
// squares of the three axes on the shared multiplier, the one-bit-pair-per-cycle square
// root, the window update and, on the same multiplier, the divide by WINDOW (reciprocal
// multiply plus one correction). in_ready is high only between samples; a finished
// result sits in an output register, so the next sample can be taken while the previous
// result is still waiting for out_ready. The correction state holds until that register
// is free, so an output stall past that point lengthens the sample.
module accel_magnitude_moving_average_unit
    import ammav_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    state_t state_reg;
    state_t state_next;

    logic [1:0]          axis_reg;
    logic [AXIS_W-1:0]   axis_mag_reg [AXES];
    logic [SUMSQ_W-1:0]  acc_reg;
    logic [SUMSQ_W-1:0]  acc_sum;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    ring_reg [WINDOW];
    logic [SLOT_W-1:0]   slot_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  quot_reg;
    logic [TOTAL_W-1:0]  remainder;
    logic [TOTAL_W-1:0]  quot_fixed;
    logic                out_valid_reg;
    out_t                out_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;

    logic                sq_start;
    logic                sq_done;
    logic [MAG_W-1:0]    sq_root;
    logic                out_free;

    ammav_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_sum),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign prod     = mul_a * mul_b;
    assign acc_sum  = acc_reg + prod[SUMSQ_W-1:0];

    // correction after the truncated reciprocal: quotient is low by at most one
    assign remainder  = total_reg - prod[TOTAL_W-1:0];
    assign quot_fixed = (remainder >= TOTAL_W'(WINDOW)) ? quot_reg + 1'b1 : quot_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SQUARE;
            ST_SQUARE:
                if (axis_reg == 2'(AXES - 1))
                    state_next = ST_ROOT;
            ST_ROOT:
                if (sq_done)
                    state_next = ST_RING;
            ST_RING:
                state_next = ST_DIV_MUL;
            ST_DIV_MUL:
                state_next = ST_DIV_FIX;
            ST_DIV_FIX:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, square root start and shared multiplier operands
    always_comb
    begin
        in_ready = 1'b0;
        sq_start = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_SQUARE:
            begin
                mul_a    = MUL_W'(axis_mag_reg[axis_reg]);
                mul_b    = MUL_W'(axis_mag_reg[axis_reg]);
                sq_start = (axis_reg == 2'(AXES - 1));
            end
            ST_DIV_MUL:
            begin
                mul_a = MUL_W'(total_reg);
                mul_b = MUL_W'(RECIP);
            end
            ST_DIV_FIX:
            begin
                mul_a = MUL_W'(quot_reg);
                mul_b = MUL_W'(WINDOW);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            slot_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
                ring_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV_FIX && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    axis_reg <= '0;
                ST_SQUARE:
                    axis_reg <= axis_reg + 1'b1;
                ST_RING:
                begin
                    total_reg <= total_reg - TOTAL_W'(ring_reg[slot_reg]) + TOTAL_W'(mag_reg);
                    ring_reg[slot_reg] <= mag_reg;
                    slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                axis_mag_reg[0] <= abs16(in_data.accel_x);
                axis_mag_reg[1] <= abs16(in_data.accel_y);
                axis_mag_reg[2] <= abs16(in_data.accel_z);
                acc_reg         <= '0;
            end
            ST_SQUARE:
                acc_reg <= acc_sum;
            ST_ROOT:
                if (sq_done)
                    mag_reg <= sq_root;
            ST_DIV_MUL:
                quot_reg <= prod[TOTAL_W +: TOTAL_W];
            ST_DIV_FIX:
                if (out_free)
                begin
                    out_reg.magnitude      <= mag_reg;
                    out_reg.window_average <= quot_fixed[MAG_W-1:0];
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside root phase");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot out of range");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TOTAL_W'(MAG_MAX * WINDOW))
        else $error("window total exceeds bound");

    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.magnitude <= MAG_W'(MAG_MAX))
        else $error("magnitude exceeds bound");

    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> out_reg.window_average <= MAG_W'(MAG_MAX))
        else $error("window average exceeds bound");

endmodule

FILE: test/tb_accel_magnitude_moving_average_unit.sv
// Self-checking testbench for the acceleration magnitude and boxcar average unit.
`timescale 1ns / 1ps

module tb_accel_magnitude_moving_average_unit;
    import ammav_pkg::*;

    localparam int RANDOM_SAMPLES = 800;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        in_t  sample;
        bit   typed;
        out_t result;
    } directed_row_t;

    // typed rows: first sample after reset, and full-scale negative axes on a window
    // that still holds only the reset zeros plus one zero magnitude
    directed_row_t directed_rows [17] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b1, '{16'd0, 16'd0}},
        '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1, '{16'd56755, 16'd11351}},
        '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0003, 16'sh0004, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'shffff, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh8000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh7fff}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'shfffd, 16'shfffc, 16'sh000c}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0001, 16'sh0001, 16'sh0001}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh8000, 16'sh7fff, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '{16'd0, 16'd0}},
        '{'{16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, '{16'd0, 16'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // predictor state: last WINDOW magnitudes, next slot, running sum
    logic [MAG_W-1:0] mag_history [WINDOW];
    int unsigned      history_slot = 0;
    longint unsigned  history_sum = 0;

    out_t expected_results [$];
    int   samples_sent = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    bit   pressure_done = 1'b0;

    accel_magnitude_moving_average_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #15_000_000;
        $display("timeout: %0d results still pending", expected_results.size());
        $display("tb_accel_magnitude_moving_average_unit: errors");
        $finish;
    end

    // floor square root by setting one root bit at a time, high to low
    function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = MAG_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return MAG_W'(root);
    endfunction

    function automatic out_t update_magnitude_average(input in_t s);
        longint          ax;
        longint          ay;
        longint          az;
        longint unsigned sq_sum;
        out_t            r;
        ax = int'(s.accel_x);
        ay = int'(s.accel_y);
        az = int'(s.accel_z);
        sq_sum = longint'(ax * ax + ay * ay + az * az);
        r.magnitude = floor_root(sq_sum);
        if (history_slot >= WINDOW)
            history_slot = 0;
        history_sum = history_sum - mag_history[history_slot] + r.magnitude;
        mag_history[history_slot] = r.magnitude;
        history_slot = (history_slot + 1) % WINDOW;
        r.window_average = MAG_W'(history_sum / WINDOW);
        return r;
    endfunction

    function automatic logic signed [AXIS_W-1:0] pick_axis();
        logic signed [AXIS_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            2:       v = '0;
            3:       v = AXIS_W'($urandom_range(0, 128)) - 16'sd64;
            default: v = AXIS_W'($urandom);
        endcase
        return v;
    endfunction

    // hold the beat until the block takes it, then log its expected result
    task automatic offer_sample(input in_t s, input bit typed, input out_t typed_result);
        out_t want;
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        want = update_magnitude_average(s);
        expected_results.push_back(typed ? typed_result : want);
        samples_sent++;
    endtask

    initial
    begin
        int   burst_left;
        int   gap;
        in_t  s;
        for (int i = 0; i < WINDOW; i++)
            mag_history[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        foreach (directed_rows[i])
            offer_sample(directed_rows[i].sample, directed_rows[i].typed,
                         directed_rows[i].result);

        burst_left = 0;
        for (int n = 0; n < RANDOM_SAMPLES; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            s.accel_x = pick_axis();
            s.accel_y = pick_axis();
            s.accel_z = pick_axis();
            offer_sample(s, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples (%0d directed), %0d results compared, %0d mismatches",
                 samples_sent, $size(directed_rows), results_checked, mismatches);
        $display("long output back-pressure stretch applied: %0d", pressure_done);
        if (mismatches == 0)
            $display("tb_accel_magnitude_moving_average_unit: clean");
        else
            $display("tb_accel_magnitude_moving_average_unit: errors");
        $finish;
    end

    // result side: compare each beat, then pick the next out_ready
    initial
    begin
        int   stall_mode;
        int   mode_left;
        out_t want;
        stall_mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing pending: mag %0d avg %0d",
                                 out_data.magnitude, out_data.window_average);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.magnitude !== want.magnitude ||
                        out_data.window_average !== want.window_average)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected mag %0d avg %0d, got mag %0d avg %0d",
                                     results_checked, want.magnitude, want.window_average,
                                     out_data.magnitude, out_data.window_average);
                    end
                    results_checked++;
                end
            end

            if (!pressure_done && results_checked >= 200)
            begin
                // sender keeps offering while results back up into the block
                pressure_done = 1'b1;
                out_ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

endmodule
